// ===== rtl/core/thc_pkg.sv =====
package thc_pkg;

    localparam logic [3:0] KEY_STAR  = 4'd10;
    localparam logic [3:0] KEY_HASH  = 4'd11;
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

    localparam logic [6:0] BAD_ENTRY = 7'd61;
    localparam logic [6:0] MIN_SEC_WRAP = 7'd60;
    localparam logic [4:0] HOUR_WRAP = 5'd12;
    localparam logic [3:0] HOUR_ELEVEN = 4'd11;
    localparam logic [3:0] HOUR_TWELVE = 4'd12;

    localparam logic [3:0] RST_HOUR   = 4'd11;
    localparam logic [5:0] RST_MINUTE = 6'd59;
    localparam logic [5:0] RST_SECOND = 6'd55;
    localparam logic       RST_PM     = 1'b1;

    // external phase codes
    localparam logic [1:0] PHASE_RUN  = 2'd0;
    localparam logic [1:0] PHASE_HOUR = 2'd1;
    localparam logic [1:0] PHASE_MIN  = 2'd2;
    localparam logic [1:0] PHASE_AMPM = 2'd3;

    typedef struct packed {
        logic [3:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       pm;
    } tod_t;

    // clock update request from the keypad sequencer
    typedef struct packed {
        logic       tick;
        logic       load;
        logic [3:0] hour;
        logic [5:0] minute;
        logic       pm;
    } clk_ctl_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       rejected;
    } entry_stat_t;

endpackage

// ===== rtl/core/thc_clock.sv =====
module thc_clock
    import thc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  clk_ctl_t ctl,
    output tod_t     tod_next
);

    tod_t tod_reg;

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [4:0] hour_inc;
    logic [5:0] sec_wrapped;
    logic [5:0] min_wrapped;
    logic [3:0] hour_wrapped;

    always_comb begin
        sec_inc  = {1'b0, tod_reg.second} + 7'd1;
        min_inc  = {1'b0, tod_reg.minute} + 7'd1;
        hour_inc = {1'b0, tod_reg.hour} + 5'd1;
        sec_wrapped  = (sec_inc >= MIN_SEC_WRAP) ? 6'(sec_inc - MIN_SEC_WRAP) : sec_inc[5:0];
        min_wrapped  = (min_inc >= MIN_SEC_WRAP) ? 6'(min_inc - MIN_SEC_WRAP) : min_inc[5:0];
        hour_wrapped = (hour_inc >= HOUR_WRAP) ? 4'(hour_inc - HOUR_WRAP) : hour_inc[3:0];

        tod_next = tod_reg;
        if (ctl.load) begin
            tod_next.hour   = ctl.hour;
            tod_next.minute = ctl.minute;
            tod_next.second = '0;
            tod_next.pm     = ctl.pm;
        end else if (ctl.tick) begin
            tod_next.second = sec_wrapped;
            if (sec_wrapped == '0) begin
                tod_next.minute = min_wrapped;
                if (min_wrapped == '0) begin
                    if (tod_reg.hour == HOUR_ELEVEN) begin
                        tod_next.hour = HOUR_TWELVE;
                        tod_next.pm   = ~tod_reg.pm;
                    end else begin
                        tod_next.hour = hour_wrapped;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tod_reg.hour   <= RST_HOUR;
            tod_reg.minute <= RST_MINUTE;
            tod_reg.second <= RST_SECOND;
            tod_reg.pm     <= RST_PM;
        end else if (step) begin
            tod_reg <= tod_next;
        end
    end

endmodule

// ===== rtl/core/thc_entry.sv =====
module thc_entry
    import thc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        mode,
    input  logic [3:0]  key,
    output clk_ctl_t    ctl,
    output entry_stat_t stat
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_HOUR = 4'b0010,
        ST_MIN  = 4'b0100,
        ST_AMPM = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [6:0] value_reg, value_next;
    logic [1:0] len_reg, len_next;
    logic       invalid_reg, invalid_next;
    logic [3:0] pend_hour_reg, pend_hour_next;
    logic [5:0] pend_min_reg, pend_min_next;

    logic [6:0] confirm_val;
    logic [6:0] lo;
    logic [6:0] hi;
    logic       reject;
    logic [1:0] phase_code;

    always_comb begin
        confirm_val = (!invalid_reg && len_reg != 2'd0 && value_reg <= 7'd59) ?
                      value_reg : BAD_ENTRY;
        lo = 7'd0;
        hi = 7'd59;
        if (phase_reg == ST_HOUR) begin
            lo = 7'd1;
            hi = 7'd12;
        end else if (phase_reg == ST_AMPM) begin
            hi = 7'd1;
        end
        reject = (confirm_val < lo) || (confirm_val > hi);

        phase_next     = phase_reg;
        value_next     = value_reg;
        len_next       = len_reg;
        invalid_next   = invalid_reg;
        pend_hour_next = pend_hour_reg;
        pend_min_next  = pend_min_reg;

        ctl.tick   = 1'b0;
        ctl.load   = 1'b0;
        ctl.hour   = pend_hour_reg;
        ctl.minute = pend_min_reg;
        ctl.pm     = confirm_val[0];
        stat.rejected = 1'b0;

        if (!mode) begin
            ctl.tick = step && (phase_reg == ST_RUN);
        end else if (phase_reg == ST_RUN) begin
            if (key == KEY_STAR) begin
                phase_next   = ST_HOUR;
                value_next   = '0;
                len_next     = '0;
                invalid_next = 1'b0;
            end
        end else if (key <= KEY_DIGIT_MAX) begin
            if (!invalid_reg) begin
                if (len_reg == 2'd0) begin
                    value_next = {3'b000, key};
                    len_next   = 2'd1;
                end else if (len_reg == 2'd1 && value_reg != '0) begin
                    // first digit is at most 9, so the sum stays below 100
                    value_next = 7'(value_reg * 7'd10 + {3'b000, key});
                    len_next   = 2'd2;
                end else begin
                    invalid_next = 1'b1;
                end
            end
        end else if (key == KEY_HASH) begin
            value_next   = '0;
            len_next     = '0;
            invalid_next = 1'b0;
            if (reject) begin
                stat.rejected = 1'b1;
            end else begin
                unique case (phase_reg)
                    ST_HOUR: begin
                        pend_hour_next = confirm_val[3:0];
                        phase_next     = ST_MIN;
                    end
                    ST_MIN: begin
                        pend_min_next = confirm_val[5:0];
                        phase_next    = ST_AMPM;
                    end
                    default: begin
                        ctl.load   = step;
                        phase_next = ST_RUN;
                    end
                endcase
            end
        end else begin
            invalid_next = 1'b1;
        end

        unique case (phase_next)
            ST_RUN:  phase_code = PHASE_RUN;
            ST_HOUR: phase_code = PHASE_HOUR;
            ST_MIN:  phase_code = PHASE_MIN;
            ST_AMPM: phase_code = PHASE_AMPM;
            default: phase_code = PHASE_RUN;
        endcase
        stat.phase = phase_code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ST_RUN;
            value_reg     <= '0;
            len_reg       <= '0;
            invalid_reg   <= 1'b0;
            pend_hour_reg <= '0;
            pend_min_reg  <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            value_reg     <= value_next;
            len_reg       <= len_next;
            invalid_reg   <= invalid_next;
            pend_hour_reg <= pend_hour_next;
            pend_min_reg  <= pend_min_next;
        end
    end

endmodule

// ===== rtl/core/twelve_hour_clock_with_keypad_set.sv =====
// Twelve-hour clock with keypad time setting.
// Input channel (s_): one transaction per tick or key press. s_tuser[0] is the
// item kind (0 one-second tick, 1 key press); s_tdata[3:0] is the key code.
// Result channel (m_): one transaction per input transaction, in order, showing
// the clock and set phase after that item was applied.
// The input register loads at the accepting edge; update logic then feeds the
// result register, which raises m_tvalid, and a receiver stall can hold it off.
// Throughput is one item per cycle when not stalled; all clock and entry
// state updates in a single combinational pass between those two registers.
// Reset (aresetn low, synchronous) sets 11:59:55 PM, running phase, an empty
// entry, and empties both registers.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; s_tready drops only when both are full.
module twelve_hour_clock_with_keypad_set
    import thc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] key, [7:4] zero
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] hour, [9:4] minute, [15:10] second, [16] is_pm,
    // [18:17] set_phase, [19] entry_rejected, [23:20] zero
    output logic [23:0] m_tdata
);

    logic        in_valid_reg;
    logic        mode_reg;
    logic [3:0]  key_reg;
    logic        out_valid_reg;
    logic [19:0] out_data_reg;
    logic        step;

    clk_ctl_t    ctl;
    entry_stat_t stat;
    tod_t        tod_next;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mode_reg <= s_tuser[0];
            key_reg  <= s_tdata[3:0];
        end
    end

    thc_entry u_entry (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .mode    (mode_reg),
        .key     (key_reg),
        .ctl     (ctl),
        .stat    (stat)
    );

    thc_clock u_clock (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .ctl      (ctl),
        .tod_next (tod_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= {stat.rejected, stat.phase, tod_next.pm, tod_next.second,
                             tod_next.minute, tod_next.hour};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // a waiting input item is never dropped
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg)
        else $error("input item lost while stalled");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("result register not loaded");

    a_hour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'd12))
        else $error("hour out of range");

    a_reject_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[18:17] != PHASE_RUN)
        else $error("reject reported while running");

endmodule
